// ===== hdl/assert_macros.svh =====
// Assertion macros used by the frame parser top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a non-overlapping implication outside reset.
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hdl/gbfp_pkg.sv =====
// Package with types and constants of the binary frame parser.
`timescale 1ns / 1ps
package gbfp_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    localparam logic [7:0] CFG_CLASS_FILTER = 8'd0;
    localparam logic [7:0] CFG_UPDATE_AT    = 8'd1;

    localparam logic [7:0] CLASS_FILTER_RST = 8'h01;
    localparam logic [7:0] UPDATE_AT_RST    = 8'h06;

    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_ID      = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CK_A    = 4'd7,
        PH_CK_B    = 4'd8
    } t_phase;

    typedef struct packed {
        logic restart;
        logic add;
    } t_sum_ctl;

endpackage

// ===== hdl/gbfp_fletcher.sv =====
// Running 8-bit Fletcher checksum over the frame header and payload.
`timescale 1ns / 1ps
module gbfp_fletcher
    import gbfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_sum_ctl   i_ctl,
    input  logic [7:0] i_byte,
    output logic [7:0] o_sum_a,
    output logic [7:0] o_sum_b
);

    logic [7:0] r_sum_a;
    logic [7:0] r_sum_b;
    logic [7:0] n_sum_a;
    logic [7:0] n_sum_b;

    always_comb begin
        n_sum_a = r_sum_a;
        n_sum_b = r_sum_b;
        if (i_ctl.restart) begin
            n_sum_a = i_byte;
            n_sum_b = i_byte;
        end else if (i_ctl.add) begin
            n_sum_a = r_sum_a + i_byte;
            n_sum_b = r_sum_b + n_sum_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_a <= '0;
            r_sum_b <= '0;
        end else begin
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
        end
    end

    assign o_sum_a = r_sum_a;
    assign o_sum_b = r_sum_b;

endmodule

// ===== hdl/gbfp_pkg_dummy_guard.sv =====
// Output register stage holding one parser result until it is taken.
`timescale 1ns / 1ps
module gbfp_out_reg
    import gbfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic        i_take,
    input  logic [31:0] i_data,
    input  logic        i_last,
    input  logic [1:0]  i_user,
    output logic        o_valid,
    output logic        o_free,
    output logic [31:0] o_data,
    output logic        o_last,
    output logic [1:0]  o_user
);

    logic        r_valid;
    logic [31:0] r_data;
    logic        r_last;
    logic [1:0]  r_user;
    logic        w_free;

    assign w_free = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free && i_load) begin
            r_data <= i_data;
            r_last <= i_last;
            r_user <= i_user;
        end
    end

    assign o_valid = r_valid;
    assign o_free  = w_free;
    assign o_data  = r_data;
    assign o_last  = r_last;
    assign o_user  = r_user;

endmodule

// ===== hdl/gnss_binary_frame_parser.sv =====
// Top level of the binary frame parser with sync search, class filter and checksum.
// The result word is registered: it is on the master side in the cycle after its input byte is taken.
// Throughput: one byte per cycle; the next byte enters in the cycle a waiting word is taken.
// The byte stalls only when the output register is full and not being taken.
// Reset (synchronous, active low) returns to sync search, clears sums and counters,
// and sets class_filter to 0x01 and update_at to 0x06.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gnss_binary_frame_parser
    import gbfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] msg_id, [23:8] payload_offset, [31:24] payload_byte
    output logic        m_axis_tlast,   // frame_end
    output logic [1:0]  m_axis_tuser    // [0] checksum_ok, [1] update_hit
);

    logic [7:0]  r_class_filter;
    logic [7:0]  r_update_at;
    t_phase      r_phase;
    t_phase      n_phase;
    logic [15:0] r_len;
    logic [15:0] n_len;
    logic [7:0]  r_id;
    logic [7:0]  n_id;
    logic [15:0] r_offset;
    logic [15:0] n_offset;
    logic [7:0]  r_ck_a;
    logic [7:0]  n_ck_a;

    logic        w_fire;
    logic        w_free;
    logic        w_load;
    logic [31:0] w_data;
    logic        w_last;
    logic [1:0]  w_user;
    logic        w_ok;
    t_sum_ctl    w_sum_ctl;
    logic [7:0]  w_sum_a;
    logic [7:0]  w_sum_b;
    logic [7:0]  w_b;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = w_free;
    assign w_fire        = s_axis_tvalid && w_free;
    assign w_b           = s_axis_tdata;
    assign w_ok          = (r_ck_a == w_sum_a) && (w_b == w_sum_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_filter <= CLASS_FILTER_RST;
            r_update_at    <= UPDATE_AT_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_CLASS_FILTER) begin
                r_class_filter <= i_cfg_data;
            end else if (i_cfg_index == CFG_UPDATE_AT) begin
                r_update_at <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_id      = r_id;
        n_offset  = r_offset;
        n_ck_a    = r_ck_a;
        w_sum_ctl = '0;
        w_load    = 1'b0;
        w_data    = '0;
        w_last    = 1'b0;
        w_user    = '0;
        if (w_fire) begin
            unique case (r_phase)
                PH_SYNC1: begin
                    if (w_b == SYNC_FIRST) n_phase = PH_SYNC2;
                end
                PH_SYNC2: begin
                    n_phase = (w_b == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
                end
                PH_CLASS: begin
                    if (w_b == r_class_filter) begin
                        w_sum_ctl.restart = 1'b1;
                        n_phase = PH_ID;
                    end else begin
                        n_phase = PH_SYNC1;
                    end
                end
                PH_ID: begin
                    n_id          = w_b;
                    w_sum_ctl.add = 1'b1;
                    n_phase       = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len         = {8'd0, w_b};
                    w_sum_ctl.add = 1'b1;
                    n_phase       = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_len         = {w_b, r_len[7:0]};
                    w_sum_ctl.add = 1'b1;
                    n_offset      = '0;
                    n_phase       = ({w_b, r_len[7:0]} == 16'd0) ? PH_CK_A : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    w_sum_ctl.add = 1'b1;
                    w_load        = 1'b1;
                    w_data        = {w_b, r_offset, r_id};
                    n_offset      = r_offset + 16'd1;
                    n_len         = r_len - 16'd1;
                    if (r_len == 16'd1) n_phase = PH_CK_A;
                end
                PH_CK_A: begin
                    n_ck_a  = w_b;
                    n_phase = PH_CK_B;
                end
                PH_CK_B: begin
                    w_load  = 1'b1;
                    w_data  = {8'd0, 16'd0, r_id};
                    w_last  = 1'b1;
                    w_user  = {w_ok && (r_id == r_update_at), w_ok};
                    n_phase = PH_SYNC1;
                end
                default: begin
                    n_phase = PH_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SYNC1;
            r_len    <= '0;
            r_id     <= '0;
            r_offset <= '0;
            r_ck_a   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_len    <= n_len;
            r_id     <= n_id;
            r_offset <= n_offset;
            r_ck_a   <= n_ck_a;
        end
    end

    gbfp_fletcher u_fletcher (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_sum_ctl),
        .i_byte  (w_b),
        .o_sum_a (w_sum_a),
        .o_sum_b (w_sum_b)
    );

    gbfp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_take  (m_axis_tready),
        .i_data  (w_data),
        .i_last  (w_last),
        .i_user  (w_user),
        .o_valid (m_axis_tvalid),
        .o_free  (w_free),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast),
        .o_user  (m_axis_tuser)
    );

    `ASSERT_CLK(a_payload_len, (r_phase == PH_PAYLOAD) |-> (r_len != 16'd0), "payload with zero length left")
    `ASSERT_NEXT(a_end_word, w_fire && (r_phase == PH_CK_B), m_axis_tvalid && m_axis_tlast, "frame end word missing")
    `ASSERT_NEXT(a_offset_step, w_fire && (r_phase == PH_PAYLOAD), r_offset == 16'($past(r_offset) + 16'd1), "payload offset did not advance")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for the binary frame parser: directed, register, random, hold and steady tests.
`timescale 1ns / 1ps
module tb_top;
    import gbfp_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 900000;
    localparam int RANDOM_BYTES = 200;
    localparam int STEADY_BYTES = 80;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 4;

    localparam logic [7:0] CFG_SPARE_FIRST = 8'd2;
    localparam logic [7:0] CFG_SPARE_LAST  = 8'hFF;

    typedef enum int {
        CK_GOOD,
        CK_BAD_A,
        CK_BAD_B
    } t_ck_fault;

    typedef struct packed {
        logic        update_hit;
        logic        checksum_ok;
        logic        frame_end;
        logic [7:0]  payload_byte;
        logic [15:0] payload_offset;
        logic [7:0]  msg_id;
    } t_word;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index   = '0;
    logic [7:0]  i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;

    // frame tracker state and register copies
    t_phase      trk_phase;
    logic [15:0] trk_remaining;
    logic [15:0] trk_offset;
    logic [7:0]  trk_sum_a;
    logic [7:0]  trk_sum_b;
    logic [7:0]  trk_id;
    logic [7:0]  trk_ck_a;
    logic [7:0]  reg_class;
    logic [7:0]  reg_update;

    t_word       pending_words[$];
    t_word       got_word;
    t_word       want_word;
    int          errors      = 0;
    int          bytes_sent  = 0;
    int          cycle_count = 0;
    bit          tx_idle_en  = 1'b1;
    bit          rx_idle_en  = 1'b1;
    bit          hold_req    = 1'b0;

    gnss_binary_frame_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic void clear_tracker();
        reg_class     = CLASS_FILTER_RST;
        reg_update    = UPDATE_AT_RST;
        trk_phase     = PH_SYNC1;
        trk_remaining = '0;
        trk_offset    = '0;
        trk_sum_a     = '0;
        trk_sum_b     = '0;
        trk_id        = '0;
        trk_ck_a      = '0;
    endfunction

    function automatic void fold_sum(input logic [7:0] b);
        trk_sum_a = trk_sum_a + b;
        trk_sum_b = trk_sum_b + trk_sum_a;
    endfunction

    function automatic void track_byte(input logic [7:0] b);
        t_word w;
        logic  ok;
        w = '0;
        case (trk_phase)
            PH_SYNC1: begin
                if (b == SYNC_FIRST) trk_phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                trk_phase = (b == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
            end
            PH_CLASS: begin
                if (b == reg_class) begin
                    trk_sum_a = '0;
                    trk_sum_b = '0;
                    fold_sum(b);
                    trk_phase = PH_ID;
                end else begin
                    trk_phase = PH_SYNC1;
                end
            end
            PH_ID: begin
                trk_id = b;
                fold_sum(b);
                trk_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                trk_remaining = {8'h00, b};
                fold_sum(b);
                trk_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                trk_remaining[15:8] = b;
                fold_sum(b);
                trk_offset = '0;
                trk_phase  = (trk_remaining == 16'd0) ? PH_CK_A : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                fold_sum(b);
                w.msg_id         = trk_id;
                w.payload_offset = trk_offset;
                w.payload_byte   = b;
                pending_words.push_back(w);
                trk_offset    = trk_offset + 16'd1;
                trk_remaining = trk_remaining - 16'd1;
                if (trk_remaining == 16'd0) trk_phase = PH_CK_A;
            end
            PH_CK_A: begin
                trk_ck_a  = b;
                trk_phase = PH_CK_B;
            end
            PH_CK_B: begin
                ok = (trk_ck_a == trk_sum_a) && (b == trk_sum_b);
                w.msg_id      = trk_id;
                w.frame_end   = 1'b1;
                w.checksum_ok = ok;
                w.update_hit  = ok && (trk_id == reg_update);
                pending_words.push_back(w);
                trk_phase = PH_SYNC1;
            end
            default: begin
                trk_phase = PH_SYNC1;
            end
        endcase
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_word = {m_axis_tuser, m_axis_tlast, m_axis_tdata};
            if (pending_words.size() == 0) begin
                $error("result word %h with none expected", got_word);
                errors++;
            end else begin
                want_word = pending_words.pop_front();
                compare_field("msg_id", 16'(want_word.msg_id), 16'(got_word.msg_id));
                compare_field("payload_offset", want_word.payload_offset,
                              got_word.payload_offset);
                compare_field("payload_byte", 16'(want_word.payload_byte),
                              16'(got_word.payload_byte));
                compare_field("frame_end", 16'(want_word.frame_end), 16'(got_word.frame_end));
                compare_field("checksum_ok", 16'(want_word.checksum_ok),
                              16'(got_word.checksum_ok));
                compare_field("update_hit", 16'(want_word.update_hit),
                              16'(got_word.update_hit));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold on request
    initial begin : rx_drive
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
                hold_left = $urandom_range(0, 14);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (tx_idle_en && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        track_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                              input logic [15:0] len, input t_ck_fault fault,
                              input bit stripes);
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        logic [7:0] pb;
        logic [7:0] head[4];
        head = '{cls, id, len[7:0], len[15:8]};
        ck_a = '0;
        ck_b = '0;
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        foreach (head[k]) begin
            ck_a = ck_a + head[k];
            ck_b = ck_b + ck_a;
            send_byte(head[k]);
        end
        for (int k = 0; k < int'(len); k++) begin
            pb   = stripes ? (k[0] ? 8'hFF : 8'h00) : 8'($urandom);
            ck_a = ck_a + pb;
            ck_b = ck_b + ck_a;
            send_byte(pb);
        end
        send_byte((fault == CK_BAD_A) ? ~ck_a : ck_a);
        send_byte((fault == CK_BAD_B) ? ~ck_b : ck_b);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val, input bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_CLASS_FILTER) reg_class = val;
        else if (idx == CFG_UPDATE_AT) reg_update = val;
        if (last) i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed();
        // bad second sync, even when it is another first sync
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        // filtered class
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(CLASS_FILTER_RST + 8'd1);
        // zero length with update hit, then extreme payload bytes with bad checksum B
        send_frame(CLASS_FILTER_RST, UPDATE_AT_RST, 16'd0, CK_GOOD, 1'b1);
        send_frame(CLASS_FILTER_RST, UPDATE_AT_RST, 16'd2, CK_BAD_B, 1'b1);
        wait_drain();
    endtask

    task automatic test_register_sweep();
        logic [7:0] cls_set[3];
        logic [7:0] upd_set[3];
        cls_set = '{8'h00, 8'hFF, 8'($urandom)};
        upd_set = '{8'hFF, 8'h00, 8'($urandom)};
        for (int s = 0; s < 3; s++) begin
            write_reg(CFG_CLASS_FILTER, cls_set[s], 1'b0);
            write_reg(CFG_UPDATE_AT, upd_set[s], 1'b0);
            // spare indexes: drop the write
            write_reg(CFG_SPARE_FIRST, 8'($urandom), 1'b0);
            write_reg(CFG_SPARE_LAST, 8'($urandom), 1'b1);
            send_frame(reg_class, reg_update, 16'($urandom_range(0, 6)), CK_GOOD, 1'b0);
            send_frame(reg_class, reg_update, 16'($urandom_range(0, 6)), CK_BAD_A, 1'b0);
            send_frame(reg_class + 8'd1, reg_update, 16'd3, CK_GOOD, 1'b0);
            send_frame(reg_class, 8'($urandom), 16'($urandom_range(0, 6)), CK_GOOD, 1'b0);
            wait_drain();
        end
        write_reg(CFG_CLASS_FILTER, CLASS_FILTER_RST, 1'b0);
        write_reg(CFG_UPDATE_AT, 8'($urandom), 1'b1);
    endtask

    task automatic test_random_traffic(input int count);
        int         target;
        int         pick;
        int         n;
        logic [7:0] id;
        logic [15:0] len;
        t_ck_fault  fault;
        target = bytes_sent + count;
        while (bytes_sent < target) begin
            pick = $urandom_range(0, 9);
            if (pick <= 6) begin
                id    = ($urandom_range(0, 2) == 0) ? reg_update : 8'($urandom);
                len   = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(9, 40))
                                                     : 16'($urandom_range(0, 8));
                fault = ($urandom_range(0, 5) == 0) ? t_ck_fault'($urandom_range(1, 2))
                                                    : CK_GOOD;
                send_frame(reg_class, id, len, fault, 1'b0);
            end else if (pick == 7) begin
                n = $urandom_range(1, 6);
                repeat (n) send_byte(8'($urandom));
            end else if (pick == 8) begin
                send_byte(SYNC_FIRST);
                send_byte(8'($urandom));
            end else begin
                send_byte(SYNC_FIRST);
                send_byte(SYNC_SECOND);
                send_byte(reg_class ^ 8'($urandom_range(1, 255)));
            end
        end
        wait_drain();
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        send_frame(reg_class, reg_update, 16'd48, CK_GOOD, 1'b0);
        wait_drain();
    endtask

    task automatic test_steady_stream();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random_traffic(STEADY_BYTES);
        send_frame(reg_class, reg_update, 16'd40, CK_GOOD, 1'b0);
        wait_drain();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        clear_tracker();
        test_directed();
        test_register_sweep();
        test_random_traffic(RANDOM_BYTES);
        test_backpressure();
        test_steady_stream();
        if (pending_words.size() != 0) begin
            $error("%0d result words never arrived", pending_words.size());
            errors++;
        end
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
